/* rtl/nla_pkg.sv */
`default_nettype none

package nla_pkg;

   localparam int MaxLandmarksDefault = 64;

   localparam int CoordW = 24;
   localparam int TagW   = 16;
   localparam int SqW    = 2 * CoordW;
   localparam int SumW   = SqW + 1;
   localparam int DistW  = 50;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD  = 2'd1,
      OP_ASSOC = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [TagW-1:0]          tag;
      logic signed [CoordW-1:0] y;
      logic signed [CoordW-1:0] x;
   } entry_type;

   typedef struct packed {
      logic            valid;
      logic            pending;
      logic [SumW-1:0] dist_sq;
      logic [TagW-1:0] tag;
   } dist_result_type;

endpackage

`default_nettype wire

/* rtl/nla_table.sv */
`default_nettype none

module nla_table #(
   parameter int MaxLandmarks = nla_pkg::MaxLandmarksDefault,
   parameter int AddrW        = (MaxLandmarks > 1) ? $clog2(MaxLandmarks) : 1
) (
   input  wire                   clock,
   input  wire                   wr_en,
   input  wire [AddrW-1:0]       wr_addr,
   input  nla_pkg::entry_type    wr_data,
   input  wire                   rd_en,
   input  wire [AddrW-1:0]       rd_addr,
   output nla_pkg::entry_type    rd_data
);

   nla_pkg::entry_type mem [MaxLandmarks];
   nla_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/nla_dist.sv */
`default_nettype none

module nla_dist (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 in_valid,
   input  nla_pkg::entry_type                  entry,
   input  wire signed [nla_pkg::CoordW-1:0]    query_x,
   input  wire signed [nla_pkg::CoordW-1:0]    query_y,
   output nla_pkg::dist_result_type            result
);

   logic signed [nla_pkg::CoordW:0] diff_x;
   logic signed [nla_pkg::CoordW:0] diff_y;
   logic signed [nla_pkg::CoordW:0] neg_x;
   logic signed [nla_pkg::CoordW:0] neg_y;

   logic                         v1_ff;
   logic [nla_pkg::CoordW-1:0]   abs_x_ff, abs_x_in;
   logic [nla_pkg::CoordW-1:0]   abs_y_ff, abs_y_in;
   logic [nla_pkg::TagW-1:0]     tag1_ff;

   logic                         v2_ff;
   logic [nla_pkg::SqW-1:0]      sq_x_ff, sq_y_ff;
   logic [nla_pkg::TagW-1:0]     tag2_ff;

   // The magnitude of a difference of two 24-bit values never exceeds 2^24 - 1.
   always_comb begin
      diff_x   = {query_x[nla_pkg::CoordW-1], query_x} - {entry.x[nla_pkg::CoordW-1], entry.x};
      diff_y   = {query_y[nla_pkg::CoordW-1], query_y} - {entry.y[nla_pkg::CoordW-1], entry.y};
      neg_x    = -diff_x;
      neg_y    = -diff_y;
      abs_x_in = diff_x[nla_pkg::CoordW] ? neg_x[nla_pkg::CoordW-1:0]
                                         : diff_x[nla_pkg::CoordW-1:0];
      abs_y_in = diff_y[nla_pkg::CoordW] ? neg_y[nla_pkg::CoordW-1:0]
                                         : diff_y[nla_pkg::CoordW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      abs_x_ff <= abs_x_in;
      abs_y_ff <= abs_y_in;
      tag1_ff  <= entry.tag;
      sq_x_ff  <= abs_x_ff * abs_x_ff;
      sq_y_ff  <= abs_y_ff * abs_y_ff;
      tag2_ff  <= tag1_ff;
   end

   always_comb begin
      result.valid   = v2_ff;
      result.pending = v1_ff | v2_ff;
      result.dist_sq = {1'b0, sq_x_ff} + {1'b0, sq_y_ff};
      result.tag     = tag2_ff;
   end

endmodule

`default_nettype wire

/* rtl/nearest_landmark_association_core.sv */
`default_nettype none

// Nearest landmark search over a table of up to MaxLandmarks entries held in
// one synchronous memory. Clear and load are done as the request is accepted.
// An associate query reads one stored entry per cycle through a four-stage
// read, distance and compare pipeline; on an empty table it offers the
// result without a scan. The result sits in an output register, so the next
// request is accepted while it waits to be taken. Distances are squared
// Euclidean, and on equal distances the earliest loaded entry wins.
module nearest_landmark_association_core #(
   parameter int MaxLandmarks = nla_pkg::MaxLandmarksDefault
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire [1:0]                         req_operation,
   input  wire signed [nla_pkg::CoordW-1:0]  req_coord_x,
   input  wire signed [nla_pkg::CoordW-1:0]  req_coord_y,
   input  wire [nla_pkg::TagW-1:0]           req_tag,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic [nla_pkg::TagW-1:0]          rsp_matched_id,
   output logic                              rsp_found,
   output logic [nla_pkg::DistW-1:0]         rsp_best_dist_sq
);

   localparam int AddrW  = (MaxLandmarks > 1) ? $clog2(MaxLandmarks) : 1;
   localparam int CountW = $clog2(MaxLandmarks + 1);

   nla_pkg::state_type state_ff, state_in;

   logic [CountW-1:0]                 count_ff, count_in;
   logic [CountW-1:0]                 scan_idx_ff, scan_idx_in;
   logic signed [nla_pkg::CoordW-1:0] qx_ff, qx_in;
   logic signed [nla_pkg::CoordW-1:0] qy_ff, qy_in;
   logic [nla_pkg::TagW-1:0]          id_ff, id_in;
   logic                              have_ff, have_in;
   logic [nla_pkg::SumW-1:0]          best_ff, best_in;
   logic                              rd_valid_ff;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [nla_pkg::TagW-1:0]          rsp_id_ff, rsp_id_in;
   logic                              rsp_found_ff, rsp_found_in;
   logic [nla_pkg::SumW-1:0]          rsp_dist_ff, rsp_dist_in;

   logic                              req_xfer;
   logic                              rd_en;
   logic                              finish_load;
   logic                              last_issue;
   logic                              wr_en;
   nla_pkg::entry_type                wr_data;
   nla_pkg::entry_type                rd_data;
   nla_pkg::dist_result_type          dres;

   // Loads happen only in IDLE and reads only in SCAN, so the memory never
   // sees a read and a write of the same entry in flight together.
   nla_table #(
      .MaxLandmarks (MaxLandmarks),
      .AddrW        (AddrW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AddrW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (scan_idx_ff[AddrW-1:0]),
      .rd_data (rd_data)
   );

   nla_dist u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_valid (rd_valid_ff),
      .entry    (rd_data),
      .query_x  (qx_ff),
      .query_y  (qy_ff),
      .result   (dres)
   );

   assign last_issue = (scan_idx_ff == count_ff - CountW'(1));

   // State machine outputs.
   always_comb begin
      req_ready   = (state_ff == nla_pkg::ST_IDLE);
      rd_en       = (state_ff == nla_pkg::ST_SCAN);
      finish_load = (state_ff == nla_pkg::ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   end

   assign req_xfer = req_valid && req_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         nla_pkg::ST_IDLE: begin
            if (req_xfer && req_operation == nla_pkg::OP_ASSOC) begin
               state_in = (count_ff == '0) ? nla_pkg::ST_FINISH : nla_pkg::ST_SCAN;
            end
         end
         nla_pkg::ST_SCAN: begin
            if (last_issue) begin
               state_in = nla_pkg::ST_DRAIN;
            end
         end
         nla_pkg::ST_DRAIN: begin
            if (!rd_valid_ff && !dres.pending) begin
               state_in = nla_pkg::ST_FINISH;
            end
         end
         nla_pkg::ST_FINISH: begin
            if (finish_load) begin
               state_in = nla_pkg::ST_IDLE;
            end
         end
         default: state_in = nla_pkg::ST_IDLE;
      endcase
   end

   // Datapath and table bookkeeping.
   always_comb begin
      count_in     = count_ff;
      scan_idx_in  = scan_idx_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      id_in        = id_ff;
      have_in      = have_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_found_in = rsp_found_ff;
      rsp_dist_in  = rsp_dist_ff;
      wr_en        = 1'b0;
      wr_data      = '{tag: req_tag, y: req_coord_y, x: req_coord_x};

      if (req_xfer) begin
         case (req_operation)
            nla_pkg::OP_CLEAR: count_in = '0;
            nla_pkg::OP_LOAD: begin
               if (count_ff < CountW'(MaxLandmarks)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CountW'(1);
               end
            end
            nla_pkg::OP_ASSOC: begin
               qx_in       = req_coord_x;
               qy_in       = req_coord_y;
               id_in       = req_tag;
               have_in     = 1'b0;
               best_in     = '0;
               scan_idx_in = '0;
            end
            default: ;
         endcase
      end

      if (rd_en) begin
         scan_idx_in = scan_idx_ff + CountW'(1);
      end

      // Only a strictly smaller distance replaces the best, so ties keep
      // the earlier entry.
      if (dres.valid && (!have_ff || dres.dist_sq < best_ff)) begin
         have_in = 1'b1;
         best_in = dres.dist_sq;
         id_in   = dres.tag;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish_load) begin
         rsp_valid_in = 1'b1;
         rsp_id_in    = id_ff;
         rsp_found_in = have_ff;
         rsp_dist_in  = best_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nla_pkg::ST_IDLE;
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_valid_ff  <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff  <= scan_idx_in;
      qx_ff        <= qx_in;
      qy_ff        <= qy_in;
      id_ff        <= id_in;
      have_ff      <= have_in;
      best_ff      <= best_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_found_ff <= rsp_found_in;
      rsp_dist_ff  <= rsp_dist_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_matched_id   = rsp_id_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_best_dist_sq = {{(nla_pkg::DistW - nla_pkg::SumW){1'b0}}, rsp_dist_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(MaxLandmarks))
      else $error("entry count exceeds table depth");

   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == nla_pkg::ST_SCAN |-> count_ff != '0)
      else $error("scan started on an empty table");

   a_dist_in_query: assert property (@(posedge clock) disable iff (reset)
      dres.valid |-> (state_ff == nla_pkg::ST_SCAN || state_ff == nla_pkg::ST_DRAIN))
      else $error("distance result outside a query");

   a_finish_after_drain: assert property (@(posedge clock) disable iff (reset)
      state_ff == nla_pkg::ST_FINISH |-> !rd_valid_ff && !dres.pending)
      else $error("result offered while the pipeline still holds entries");

endmodule

`default_nettype wire
